/* src/pic_pkg.sv */
`default_nettype none

package pic_pkg;

    // number of cache entries, one cell each
    localparam int ENTRIES = 4;
    // width of the fill count, holds 0 to ENTRIES
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_RESET  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_EMPTY = 2'd0,
        MODE_MONO  = 2'd1,
        MODE_POLY  = 2'd2,
        MODE_MEGA  = 2'd3
    } mode_t;

    // one item traveling down the cell chain
    typedef struct packed {
        logic        valid;
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [31:0] offset;
        logic [63:0] target;
        logic        found;
        logic        appended;
        logic [63:0] hit_target;
        logic [31:0] hit_offset;
    } pic_item_t;

endpackage

`default_nettype wire

/* src/pic_cell.sv */
`default_nettype none

module pic_cell (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic [pic_pkg::CNT_W-1:0] cell_index,
    input  wire logic [pic_pkg::CNT_W-1:0] fill_count,
    input  wire pic_pkg::pic_item_t      item_in,
    output pic_pkg::pic_item_t           item_out
);

    import pic_pkg::*;

    logic [31:0] key_reg;
    logic [31:0] offset_reg;
    logic [63:0] target_reg;
    pic_item_t   item_reg;
    pic_item_t   item_next;

    logic live;
    logic active;
    logic is_record;
    logic match;
    logic append;

    // compare against this cell's entry, claim the free slot on a record miss
    always_comb
    begin
        is_record = (item_in.cmd == CMD_RECORD);
        live      = (cell_index < fill_count);
        active    = item_in.valid && !item_in.found && (item_in.key != 32'd0)
                    && (is_record || (item_in.cmd == CMD_LOOKUP));
        match     = active && live && (key_reg == item_in.key);
        append    = active && is_record && (cell_index == fill_count);

        item_next = item_in;
        if (match)
        begin
            item_next.found      = 1'b1;
            item_next.hit_target = is_record ? item_in.target : target_reg;
            item_next.hit_offset = offset_reg;
        end
        if (append)
        begin
            item_next.appended = 1'b1;
        end
    end

    // hand the item to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (en)
        begin
            item_reg <= item_next;
        end
    end

    // entry storage, written on a record hit or an append
    always_ff @(posedge clk)
    begin
        if (en && match && is_record)
        begin
            target_reg <= item_in.target;
        end
        else if (en && append)
        begin
            key_reg    <= item_in.key;
            offset_reg <= item_in.offset;
            target_reg <= item_in.target;
        end
    end

    assign item_out = item_reg;

endmodule

`default_nettype wire

/* src/polymorphic_inline_cache.sv */
// Polymorphic inline cache: up to ENTRIES entries mapping a nonzero type key
// to a code pointer and a method offset.
// Input channel s_*: s_tuser carries the command (record, lookup, reset
// cache); s_tdata carries type_key, offset_in and target_in.
// Output channel m_*: one result item per input item; m_tuser is the hit
// flag, m_tdata holds the matched pointer and offset (zero on no match)
// followed by mode, entry count and the hit and miss counters after the item.
// Each item walks a chain of ENTRIES cells, one cell per cycle while the chain is
// not held, starting at the accepting edge; as it leaves the last cell it updates
// the status and loads the output register. One item is in flight at a time and
// s_tready returns with m_tvalid, so a new item is accepted only once the result
// of the last one is loaded.
// After rst_n the cache is empty and the counters are zero; no clearing pass
// is needed. The reset-cache command does the same in one item.
// When the receiver stalls with a result waiting and a new item reaches the
// end of the chain, the chain holds until the result is taken.
`default_nettype none

module polymorphic_inline_cache (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // type_key[31:0], offset_in[63:32], target_in[127:64]
    input  wire logic [127:0] s_tdata,
    // command[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // target_out[63:0], offset_out[95:64], cache_mode[97:96],
    // used_entries[100:98], hits_total[132:101], misses_total[164:133], zero pad
    output logic [167:0]      m_tdata,
    // hit[0]
    output logic [0:0]        m_tuser
);

    import pic_pkg::*;

    pic_item_t chain [ENTRIES+1];
    pic_item_t head;
    logic [ENTRIES:0] chain_valid;

    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    mode_t            mode_reg;
    mode_t            mode_next;
    logic [31:0]      hits_reg;
    logic [31:0]      hits_next;
    logic [31:0]      misses_reg;
    logic [31:0]      misses_next;

    logic             out_valid_reg;
    logic             out_hit_reg;
    logic [63:0]      out_target_reg;
    logic [31:0]      out_offset_reg;

    logic      accept;
    logic      advance;
    logic      load;
    pic_item_t last;

    // input item enters the first cell
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        head        = '0;
        head.valid  = accept;
        head.cmd    = s_tuser;
        head.key    = s_tdata[31:0];
        head.offset = s_tdata[63:32];
        head.target = s_tdata[127:64];
    end

    assign chain[0] = head;

    assign last    = chain[ENTRIES];
    assign advance = !(last.valid && out_valid_reg && !m_tready);
    assign load    = last.valid && advance;

    // row of cells, one entry each
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        pic_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (advance),
            .cell_index (CNT_W'(i)),
            .fill_count (fill_reg),
            .item_in    (chain[i]),
            .item_out   (chain[i+1])
        );
    end

    for (genvar i = 0; i <= ENTRIES; i++)
    begin : g_valid
        assign chain_valid[i] = chain[i].valid;
    end

    // status update once the item leaves the chain
    always_comb
    begin
        fill_next   = fill_reg;
        mode_next   = mode_reg;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        busy_next   = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (load)
        begin
            busy_next = 1'b0;
            if (last.cmd == CMD_RESET)
            begin
                fill_next   = '0;
                mode_next   = MODE_EMPTY;
                hits_next   = 32'd0;
                misses_next = 32'd0;
            end
            else if ((last.cmd == CMD_RECORD) && (last.key != 32'd0))
            begin
                if (last.found)
                begin
                    hits_next = hits_reg + 32'd1;
                end
                else
                begin
                    misses_next = misses_reg + 32'd1;
                    if (last.appended)
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                        mode_next = (fill_reg == '0) ? MODE_MONO : MODE_POLY;
                    end
                    else
                    begin
                        mode_next = MODE_MEGA;
                    end
                end
            end
        end
    end

    // control and status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            fill_reg      <= '0;
            mode_reg      <= MODE_EMPTY;
            hits_reg      <= 32'd0;
            misses_reg    <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            fill_reg   <= fill_next;
            mode_reg   <= mode_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_hit_reg    <= last.found;
            out_target_reg <= last.found ? last.hit_target : 64'd0;
            out_offset_reg <= last.found ? last.hit_offset : 32'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {3'd0, misses_reg, hits_reg, 3'(fill_reg), mode_reg,
                       out_offset_reg, out_target_reg};

    // checks
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(ENTRIES))
        else $error("fill count beyond entry count");

    a_mega_full: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_MEGA) |-> (fill_reg == CNT_W'(ENTRIES)))
        else $error("megamorphic mode with free entries");

    a_empty_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_EMPTY) == (fill_reg == '0))
        else $error("empty mode and fill count disagree");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one item in the cell chain");

    a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("item accepted without marking busy");

endmodule

`default_nettype wire
